/* rtl/ttc_pkg.sv */
// Shared types, constants and codes of the thermistor temperature conditioner.
package ttc_pkg;

  // Default converter resolution and fixed widths of the arithmetic units.
  localparam int CODE_BITS_DEF = 12;
  localparam int LOG_IN_W     = 20;
  localparam int LOG_K_W      = 5;
  localparam int LOG_FRAC_W   = 32;
  localparam int LOG_RES_W    = LOG_K_W + LOG_FRAC_W;
  localparam int L2_W         = 40;
  localparam int DIV_NUM_W    = 62;
  localparam int DIV_DEN_W    = 56;
  localparam int DIV_CNT_W    = 6;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_ADDR_W   = 3;

  // ln(2) in Q30 and 273.15 K in deci-kelvin Q10.
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [22:0] KELVIN_Q10 = 23'd2797056;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_READ_FAIL = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SERIES_R   = 3'd0,
    REG_NOMINAL_R  = 3'd1,
    REG_NOMINAL_T  = 3'd2,
    REG_BETA       = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_MIN        = 3'd5,
    REG_MAX        = 3'd6,
    REG_AVG_LEN    = 3'd7
  } reg_idx_t;

  // Input beat.
  typedef struct packed {
    logic               sample_kind;
    logic [11:0]        adc_code;
    logic signed [15:0] digital_temp_dc;
    logic               read_failed;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] current_dc;
    logic signed [15:0] average_dc;
  } out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [19:0]        series_resistance_ohm;
    logic [19:0]        nominal_resistance_ohm;
    logic signed [11:0] nominal_temp_dc;
    logic [13:0]        beta_kelvin;
    logic signed [15:0] temp_offset;
    logic signed [15:0] min_dc;
    logic signed [15:0] max_dc;
    logic [7:0]         average_length;
  } cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_FAIL,
    DP_ERR,
    DP_L2_CLR,
    DP_LOG_GO,
    DP_LOG_ACC,
    DP_MAG,
    DP_LN,
    DP_PART_GO,
    DP_PART_LD,
    DP_BASE_GO,
    DP_BASE_LD,
    DP_INV,
    DP_T_GO,
    DP_KELV,
    DP_COND,
    DP_AVG_GO,
    DP_AVG_LD,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] log_sel;
  } cmd_t;

  typedef struct packed {
    logic read_failed;
    logic is_ntc;
    logic ntc_bad;
    logic log_done;
    logic div_done;
    logic inv_bad;
    logic q_bad;
    logic need_avg;
  } sts_t;

endpackage

/* rtl/ttc_log2.sv */
// Iterative base-2 logarithm in Q32, one squaring step per cycle.
module ttc_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ttc_pkg::LOG_IN_W-1:0]  x,
  output logic                          done,
  output logic [ttc_pkg::LOG_RES_W-1:0] res
);

  logic [ttc_pkg::LOG_K_W-1:0]    k;
  logic [31:0]                    m_init;
  logic [63:0]                    sq;
  logic [32:0]                    sh;
  logic [31:0]                    m_r;
  logic [ttc_pkg::LOG_K_W-1:0]    k_r;
  logic [ttc_pkg::LOG_FRAC_W-1:0] frac_r;
  logic [4:0]                     bit_r;
  logic                           busy_r;
  logic                           done_r;

  // Integer part: position of the leading one.
  always_comb begin
    k = '0;
    for (int i = 0; i < ttc_pkg::LOG_IN_W; i++) begin
      if (x[i]) begin
        k = ttc_pkg::LOG_K_W'(i);
      end
    end
    m_init = 32'(x) << (5'd31 - k);
  end

  // Square the mantissa; an overflow past two yields a fraction bit.
  assign sq = m_r * m_r;
  assign sh = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r    <= m_init;
      k_r    <= k;
      frac_r <= '0;
      bit_r  <= 5'd31;
    end else if (busy_r) begin
      if (sh[32]) begin
        m_r           <= sh[32:1];
        frac_r[bit_r] <= 1'b1;
      end else begin
        m_r <= sh[31:0];
      end
      bit_r <= bit_r - 5'd1;
    end
  end

  assign done = done_r;
  assign res  = {k_r, frac_r};

endmodule

/* rtl/ttc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ttc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ttc_pkg::DIV_NUM_W-1:0] num,
  input  logic [ttc_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [ttc_pkg::DIV_NUM_W-1:0] quo
);

  logic [ttc_pkg::DIV_DEN_W-1:0] rem_r;
  logic [ttc_pkg::DIV_DEN_W-1:0] den_r;
  logic [ttc_pkg::DIV_NUM_W-1:0] quo_r;
  logic [ttc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ttc_pkg::DIV_DEN_W:0]   trial;
  logic                          fits;

  // Bring down the next numerator bit and try a subtraction.
  assign trial = {rem_r, quo_r[ttc_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
      cnt_r <= ttc_pkg::DIV_CNT_W'(ttc_pkg::DIV_NUM_W - 1);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= ttc_pkg::DIV_DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[ttc_pkg::DIV_DEN_W-1:0];
      end
      quo_r <= {quo_r[ttc_pkg::DIV_NUM_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/ttc_datapath.sv */
// Conversion datapath: Beta equation, offset, clamp and block average.
module ttc_datapath #(
  parameter int CODE_BITS = ttc_pkg::CODE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ttc_pkg::cmd_t cmd,
  input  ttc_pkg::cfg_t cfg,
  input  ttc_pkg::in_t  in_data,
  output ttc_pkg::sts_t sts,
  output ttc_pkg::out_t out_data
);

  localparam int FULL = (1 << CODE_BITS) - 1;
  localparam logic [19:0] FULL20 = 20'(FULL);
  localparam logic [ttc_pkg::DIV_NUM_W-1:0] NUM_BASE = ttc_pkg::DIV_NUM_W'(20) << 48;
  localparam logic [ttc_pkg::DIV_NUM_W-1:0] NUM_TEMP = ttc_pkg::DIV_NUM_W'(10) << 58;

  ttc_pkg::in_t  in_r;
  ttc_pkg::out_t out_r;
  logic [1:0]          status_r;
  logic signed [39:0]  l2_r;
  logic                neg_r;
  logic [39:0]         mag_r;
  logic [37:0]         lnmag_r;
  logic [53:0]         part_r;
  logic [43:0]         base_r;
  logic signed [55:0]  inv_r;
  logic signed [15:0]  t_r;
  logic                q_bad_r;
  logic signed [15:0]  current_r;
  logic signed [15:0]  average_r;
  logic signed [23:0]  sum_r;
  logic [7:0]          count_r;

  logic [19:0]                     code20;
  logic [ttc_pkg::LOG_IN_W-1:0]    log_x;
  logic                            log_done;
  logic [ttc_pkg::LOG_RES_W-1:0]   log_res;
  logic signed [14:0]              tn20;
  logic                            div_start;
  logic [ttc_pkg::DIV_NUM_W-1:0]   div_num;
  logic [ttc_pkg::DIV_DEN_W-1:0]   div_den;
  logic                            div_done;
  logic [ttc_pkg::DIV_NUM_W-1:0]   div_quo;
  logic [39:0]                     mag_nxt;
  logic [61:0]                     ln_prod;
  logic signed [55:0]              inv_nxt;
  logic signed [62:0]              kx;
  logic [62:0]                     kx_mag;
  logic [52:0]                     kq_mag;
  logic signed [15:0]              t_off;
  logic signed [15:0]              t_lo;
  logic signed [15:0]              t_cl;
  logic [7:0]                      count_inc;
  logic [23:0]                     sum_abs;

  assign code20 = 20'(in_r.adc_code);

  // Logarithm operand select: Rs, code, full scale minus code, Rn.
  always_comb begin
    case (cmd.log_sel)
      2'd0:    log_x = cfg.series_resistance_ohm;
      2'd1:    log_x = code20;
      2'd2:    log_x = FULL20 - code20;
      default: log_x = cfg.nominal_resistance_ohm;
    endcase
  end

  ttc_log2 u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == ttc_pkg::DP_LOG_GO),
    .x     (log_x),
    .done  (log_done),
    .res   (log_res)
  );

  // Twice the nominal temperature in deci-kelvin.
  assign tn20 = $signed({{2{cfg.nominal_temp_dc[11]}}, cfg.nominal_temp_dc, 1'b0})
              + 15'sd5463;
  assign sum_abs = sum_r[23] ? 24'(-sum_r) : 24'(sum_r);

  // Divider operand select for the three conversion divides and the average.
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      ttc_pkg::DP_PART_GO: begin
        div_num = ttc_pkg::DIV_NUM_W'({lnmag_r, 16'b0});
        div_den = ttc_pkg::DIV_DEN_W'(cfg.beta_kelvin);
      end
      ttc_pkg::DP_BASE_GO: begin
        div_num = NUM_BASE;
        div_den = ttc_pkg::DIV_DEN_W'(tn20[13:0]);
      end
      ttc_pkg::DP_T_GO: begin
        div_num = NUM_TEMP;
        div_den = inv_r[ttc_pkg::DIV_DEN_W-1:0];
      end
      ttc_pkg::DP_AVG_GO: begin
        div_num = ttc_pkg::DIV_NUM_W'(sum_abs);
        div_den = ttc_pkg::DIV_DEN_W'(cfg.average_length);
      end
      default: div_start = 1'b0;
    endcase
  end

  ttc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Magnitude of ln(R/Rn) and the Beta terms of 1/T.
  assign mag_nxt = l2_r[39] ? 40'(-l2_r) : 40'(l2_r);
  assign ln_prod = 62'(mag_r[37:6]) * 62'(ttc_pkg::LN2_Q30);
  assign inv_nxt = neg_r ? $signed({12'b0, base_r}) - $signed({2'b0, part_r})
                         : $signed({12'b0, base_r}) + $signed({2'b0, part_r});

  // Deci-kelvin to deci-degree, truncated toward zero.
  assign kx     = $signed({1'b0, div_quo}) - $signed(63'(ttc_pkg::KELVIN_Q10));
  assign kx_mag = kx[62] ? 63'(-kx) : 63'(kx);
  assign kq_mag = kx_mag[62:10];

  // Offset with wrap, then lower and upper clamp.
  assign t_off = t_r + cfg.temp_offset;
  assign t_lo  = (t_off < cfg.min_dc) ? cfg.min_dc : t_off;
  assign t_cl  = (t_lo > cfg.max_dc) ? cfg.max_dc : t_lo;
  assign count_inc = count_r + 8'd1;

  // Architectural state of the sensor channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_r <= '0;
      average_r <= '0;
      sum_r     <= '0;
      count_r   <= '0;
    end else begin
      case (cmd.op)
        ttc_pkg::DP_COND: begin
          if (!q_bad_r) begin
            current_r <= t_cl;
            if (cfg.average_length > 8'd1) begin
              sum_r   <= sum_r + $signed({{8{t_cl[15]}}, t_cl});
              count_r <= count_inc;
            end else begin
              average_r <= t_cl;
            end
          end
        end
        ttc_pkg::DP_AVG_LD: begin
          average_r <= sum_r[23] ? 16'(-div_quo[15:0]) : div_quo[15:0];
          sum_r     <= '0;
          count_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of one conversion.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ttc_pkg::DP_LOAD: begin
        in_r     <= in_data;
        t_r      <= in_data.digital_temp_dc;
        q_bad_r  <= 1'b0;
        status_r <= ttc_pkg::ST_OK;
      end
      ttc_pkg::DP_FAIL:   status_r <= ttc_pkg::ST_READ_FAIL;
      ttc_pkg::DP_ERR:    status_r <= ttc_pkg::ST_RANGE;
      ttc_pkg::DP_L2_CLR: l2_r <= '0;
      ttc_pkg::DP_LOG_ACC: begin
        if (cmd.log_sel[1]) begin
          l2_r <= l2_r - $signed(40'(log_res));
        end else begin
          l2_r <= l2_r + $signed(40'(log_res));
        end
      end
      ttc_pkg::DP_MAG: begin
        mag_r <= mag_nxt;
        neg_r <= l2_r[39];
      end
      ttc_pkg::DP_LN:      lnmag_r <= ln_prod[61:24];
      ttc_pkg::DP_PART_LD: part_r  <= div_quo[53:0];
      ttc_pkg::DP_BASE_LD: base_r  <= div_quo[43:0];
      ttc_pkg::DP_INV:     inv_r   <= inv_nxt;
      ttc_pkg::DP_KELV: begin
        q_bad_r <= !kx[62] && (kq_mag > 53'd32767);
        t_r     <= kx[62] ? 16'(-kq_mag[15:0]) : kq_mag[15:0];
      end
      ttc_pkg::DP_OUT: begin
        out_r.status     <= status_r;
        out_r.current_dc <= current_r;
        out_r.average_dc <= average_r;
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller.
  always_comb begin
    sts.read_failed = in_r.read_failed;
    sts.is_ntc      = in_r.sample_kind;
    sts.ntc_bad     = (code20 == 20'd0) || (code20 >= FULL20)
                   || (cfg.series_resistance_ohm == 20'd0)
                   || (cfg.nominal_resistance_ohm == 20'd0)
                   || (cfg.beta_kelvin == 14'd0);
    sts.log_done    = log_done;
    sts.div_done    = div_done;
    sts.inv_bad     = inv_r[55] || (inv_r == 56'sd0);
    sts.q_bad       = q_bad_r;
    sts.need_avg    = (cfg.average_length > 8'd1) && (count_inc >= cfg.average_length);
  end

  assign out_data = out_r;

endmodule

/* rtl/ttc_ctrl.sv */
// Sequencing state machine and handshake control of the conditioner.
module ttc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ttc_pkg::sts_t sts,
  output ttc_pkg::cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_CHECK     = 17'h00002,
    S_LOG_GO    = 17'h00004,
    S_LOG_WAIT  = 17'h00008,
    S_MAG       = 17'h00010,
    S_LN        = 17'h00020,
    S_PART_GO   = 17'h00040,
    S_PART_WAIT = 17'h00080,
    S_BASE_GO   = 17'h00100,
    S_BASE_WAIT = 17'h00200,
    S_INV       = 17'h00400,
    S_T_GO      = 17'h00800,
    S_T_WAIT    = 17'h01000,
    S_COND      = 17'h02000,
    S_AVG_GO    = 17'h04000,
    S_AVG_WAIT  = 17'h08000,
    S_DONE      = 17'h10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and datapath command.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd.op      = ttc_pkg::DP_NOP;
    cmd.log_sel = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ttc_pkg::DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.read_failed) begin
          cmd.op    = ttc_pkg::DP_FAIL;
          state_nxt = S_DONE;
        end else if (!sts.is_ntc) begin
          state_nxt = S_COND;
        end else if (sts.ntc_bad) begin
          cmd.op    = ttc_pkg::DP_ERR;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ttc_pkg::DP_L2_CLR;
          idx_nxt   = 2'd0;
          state_nxt = S_LOG_GO;
        end
      end
      S_LOG_GO: begin
        cmd.op    = ttc_pkg::DP_LOG_GO;
        state_nxt = S_LOG_WAIT;
      end
      S_LOG_WAIT: begin
        if (sts.log_done) begin
          cmd.op = ttc_pkg::DP_LOG_ACC;
          if (idx_r == 2'd3) begin
            state_nxt = S_MAG;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_LOG_GO;
          end
        end
      end
      S_MAG: begin
        cmd.op    = ttc_pkg::DP_MAG;
        state_nxt = S_LN;
      end
      S_LN: begin
        cmd.op    = ttc_pkg::DP_LN;
        state_nxt = S_PART_GO;
      end
      S_PART_GO: begin
        cmd.op    = ttc_pkg::DP_PART_GO;
        state_nxt = S_PART_WAIT;
      end
      S_PART_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = ttc_pkg::DP_PART_LD;
          state_nxt = S_BASE_GO;
        end
      end
      S_BASE_GO: begin
        cmd.op    = ttc_pkg::DP_BASE_GO;
        state_nxt = S_BASE_WAIT;
      end
      S_BASE_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = ttc_pkg::DP_BASE_LD;
          state_nxt = S_INV;
        end
      end
      S_INV: begin
        cmd.op    = ttc_pkg::DP_INV;
        state_nxt = S_T_GO;
      end
      S_T_GO: begin
        if (sts.inv_bad) begin
          cmd.op    = ttc_pkg::DP_ERR;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ttc_pkg::DP_T_GO;
          state_nxt = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = ttc_pkg::DP_KELV;
          state_nxt = S_COND;
        end
      end
      S_COND: begin
        if (sts.q_bad) begin
          cmd.op    = ttc_pkg::DP_ERR;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ttc_pkg::DP_COND;
          state_nxt = sts.need_avg ? S_AVG_GO : S_DONE;
        end
      end
      S_AVG_GO: begin
        cmd.op    = ttc_pkg::DP_AVG_GO;
        state_nxt = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = ttc_pkg::DP_AVG_LD;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op    = ttc_pkg::DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result beat is held until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.op == ttc_pkg::DP_OUT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/thermistor_temp_conditioner_top.sv */
// Top level of the thermistor temperature conditioner with its register file.
//
// One sample beat in gives one result beat out. A failed read and a digital
// sample skip the Beta equation; an NTC code runs four logarithms on one shared
// squaring unit and three divides on one shared restoring divider of 62
// quotient bits. Closing an averaging block adds one more divide. A finished
// result sits in the output register, and the next sample is taken while it
// waits there.
module thermistor_temp_conditioner_top #(
  parameter int CODE_BITS = ttc_pkg::CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ttc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ttc_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ttc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ttc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ttc_pkg::cfg_t cfg_r;
  ttc_pkg::cmd_t cmd;
  ttc_pkg::sts_t sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.series_resistance_ohm  <= 20'd10000;
      cfg_r.nominal_resistance_ohm <= 20'd10000;
      cfg_r.nominal_temp_dc        <= 12'sd250;
      cfg_r.beta_kelvin            <= 14'd3950;
      cfg_r.temp_offset            <= 16'sd0;
      cfg_r.min_dc                 <= 16'sh8000;
      cfg_r.max_dc                 <= 16'sh7FFF;
      cfg_r.average_length         <= 8'd1;
    end else if (cfg_we) begin
      case (ttc_pkg::reg_idx_t'(cfg_addr))
        ttc_pkg::REG_SERIES_R:  cfg_r.series_resistance_ohm  <= cfg_wdata;
        ttc_pkg::REG_NOMINAL_R: cfg_r.nominal_resistance_ohm <= cfg_wdata;
        ttc_pkg::REG_NOMINAL_T: cfg_r.nominal_temp_dc        <= cfg_wdata[11:0];
        ttc_pkg::REG_BETA:      cfg_r.beta_kelvin            <= cfg_wdata[13:0];
        ttc_pkg::REG_OFFSET:    cfg_r.temp_offset            <= cfg_wdata[15:0];
        ttc_pkg::REG_MIN:       cfg_r.min_dc                 <= cfg_wdata[15:0];
        ttc_pkg::REG_MAX:       cfg_r.max_dc                 <= cfg_wdata[15:0];
        ttc_pkg::REG_AVG_LEN:   cfg_r.average_length         <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttc_datapath #(
    .CODE_BITS (CODE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
